// ===== src/asz_pkg.sv =====
package asz_pkg;

    // Number of boundary registers in the register map.
    localparam int NUM_BOUND_REGS = 7;
    localparam int NBUCKETS       = 8;
    localparam int NOPS           = 3;
    localparam int CNT_W          = 32;
    localparam int BOUND_W        = 32;
    localparam int MODCNT_W       = 5;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT = 3'd7;

    localparam logic [MODCNT_W-1:0] MODULE_COUNT_RESET = 5'd16;

    typedef logic [NUM_BOUND_REGS-1:0][BOUND_W-1:0] t_bounds;

    localparam t_bounds BOUNDARY_RESET = {
        32'd65536, 32'd16384, 32'd4096, 32'd1024, 32'd256, 32'd64, 32'd16
    };

    // Operation selector.
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Read scope.
    localparam logic SCOPE_MODULE = 1'b0;
    localparam logic SCOPE_GLOBAL = 1'b1;

    // Record types.
    localparam logic [1:0] REC_MALLOC  = 2'd0;
    localparam logic [1:0] REC_FREE    = 2'd1;
    localparam logic [1:0] REC_REALLOC = 2'd2;
    localparam logic [1:0] REC_UNKNOWN = 2'd3;

    // Read items: buckets below this code, operation totals from it on.
    localparam logic [3:0] ITEM_TOTAL_BASE = 4'd8;
    localparam logic [3:0] ITEM_TOTAL_LAST = 4'd10;

    typedef enum logic [2:0] {
        ST_COUNTED      = 3'd0,
        ST_BAD_MODULE   = 3'd1,
        ST_UNKNOWN_TYPE = 3'd2,
        ST_SKIPPED      = 3'd3,
        ST_READ_DATA    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_MOD_BUCKET,
        SRC_MOD_TOTAL,
        SRC_GLB_BUCKET,
        SRC_GLB_TOTAL
    } t_rd_src;

    // One input word after unpacking.
    typedef struct packed {
        logic        op;
        logic        stream_first;
        logic [1:0]  rec_type;
        logic [7:0]  module_req;
        logic [31:0] block_size;
        logic        read_scope;
        logic [3:0]  read_item;
    } t_rec;

    // Decoded work for the update stage.
    typedef struct packed {
        t_status    status;
        logic [2:0] bucket;
        t_rd_src    src;
        logic [1:0] rec_type;
        logic [3:0] read_item;
        logic       counted;
        logic       inc_bucket;
    } t_work;

endpackage

// ===== src/asz_bin.sv =====
module asz_bin
    import asz_pkg::*;
#(
    parameter int NUM_BOUNDARIES = 7
) (
    input  t_bounds     i_bounds,
    input  logic [31:0] i_size,
    output logic [2:0]  o_bucket
);

    // Every compare runs in parallel; the exceeded boundary with the highest index wins,
    // which matches a downward search even when boundaries are unsorted.
    always_comb begin
        o_bucket = '0;
        for (int i = 0; i < NUM_BOUNDARIES; i++) begin
            if (i_size > i_bounds[i]) begin
                o_bucket = 3'(i + 1);
            end
        end
    end

endmodule

// ===== src/asz_ram.sv =====
module asz_ram #(
    parameter int AW = 7,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the contents before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== src/alloc_size_histogram.sv =====
// Allocation size histogram engine.
// Input words arrive on the slave stream (i_s_*). tuser carries the operation:
// 0 counts one trace record, 1 reads one counter. A counted malloc or realloc
// is binned by size against the boundary registers and bumps a per-module and
// a global bucket counter plus the per-module and global operation totals;
// a free bumps the totals only. All counters are 32 bits and saturate.
// Results leave on the master stream (o_m_*), one word per input word, in order.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); it
// should be written only while no word is in flight.
// From the accepting edge to o_m_tvalid, the input register, then the stage that
// holds the counter memory read data, then the result register load in turn.
// Throughput is one word per cycle while the receiver keeps up and no clearing
// pass runs; a read-modify-write to the same counter on back-to-back words is forwarded from the write port.
// After reset the per-module counter memories are cleared one entry per cycle,
// a pass over 2**(clog2(MAX_MODULES) + 3) entries with clog2 taken as at least 1
// (128 with the defaults); o_s_tready stays low during that pass. Global
// counters and the skip flag clear at once.
// When the receiver stalls, the result register holds and back pressure moves
// stage by stage to o_s_tready, so no word is lost or repeated.
module alloc_size_histogram
    import asz_pkg::*;
#(
    parameter int NUM_BOUNDARIES = 7,
    parameter int MAX_MODULES    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: stream_first[0], rec_type[2:1], module_req[10:3],
    //        block_size[42:11], read_scope[43], read_item[47:44]
    input  logic [47:0]          i_s_tdata,
    // tuser: op[0]
    input  logic [0:0]           i_s_tuser,
    // Result stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: bucket[2:0], read_value[34:3], zero fill [39:35]
    output logic [39:0]          o_m_tdata,
    // tuser: status[2:0]
    output logic [2:0]           o_m_tuser,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BOUND_W-1:0]   i_cfg_data
);

    localparam int MW  = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int BAW = MW + 3;
    localparam int TAW = MW + 2;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Configuration registers.
    t_bounds             r_bounds;
    logic [MODCNT_W-1:0] r_modcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds <= BOUNDARY_RESET;
            r_modcnt <= MODULE_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODULE_COUNT) begin
                r_modcnt <= i_cfg_data[MODCNT_W-1:0];
            end else begin
                r_bounds[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // Memory clearing pass after reset.
    logic           r_clr_busy;
    logic [BAW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Pipeline control.
    logic r_a_valid, r_b_valid, r_o_valid;
    logic fire_a, fire_b, b_free, a_free, o_space;

    assign o_space    = !r_o_valid || i_m_tready;
    assign fire_b     = r_b_valid && o_space;
    assign b_free     = !r_b_valid || fire_b;
    assign fire_a     = r_a_valid && b_free;
    assign a_free     = !r_a_valid || fire_a;
    assign o_s_tready = a_free && !r_clr_busy;

    // Input register.
    t_rec r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_a.op           <= i_s_tuser[0];
            r_a.stream_first <= i_s_tdata[0];
            r_a.rec_type     <= i_s_tdata[2:1];
            r_a.module_req   <= i_s_tdata[10:3];
            r_a.block_size   <= i_s_tdata[42:11];
            r_a.read_scope   <= i_s_tdata[43];
            r_a.read_item    <= i_s_tdata[47:44];
        end
    end

    // Decode stage: classify the word, bin its size and address the memories.
    logic [2:0]     bin_bucket;
    logic           r_skip;
    logic           a_skip_next;
    logic           mod_in_range;
    logic           mod_bad;
    logic           skip_eff;
    t_work          a_work;
    logic [BAW-1:0] a_baddr;
    logic [TAW-1:0] a_taddr;

    asz_bin #(
        .NUM_BOUNDARIES(NUM_BOUNDARIES)
    ) u_bin (
        .i_bounds(r_bounds),
        .i_size  (r_a.block_size),
        .o_bucket(bin_bucket)
    );

    always_comb begin
        mod_in_range = {1'b0, r_a.module_req} < 9'(MAX_MODULES);
        mod_bad      = !mod_in_range ||
                       ({1'b0, r_a.module_req} >= {4'b0, r_modcnt});
        // A stream start on a count word clears the skip flag before the record is examined.
        skip_eff     = r_skip && !r_a.stream_first;

        a_work            = '0;
        a_work.rec_type   = r_a.rec_type;
        a_work.read_item  = r_a.read_item;
        a_work.src        = SRC_ZERO;
        a_work.status     = ST_COUNTED;
        a_skip_next       = r_skip;

        if (r_a.op == OP_READ) begin
            a_work.status = ST_READ_DATA;
            if (r_a.read_item < ITEM_TOTAL_BASE) begin
                if ({1'b0, r_a.read_item[2:0]} <= 4'(NUM_BOUNDARIES)) begin
                    if (r_a.read_scope == SCOPE_GLOBAL) begin
                        a_work.src = SRC_GLB_BUCKET;
                    end else if (mod_in_range) begin
                        a_work.src = SRC_MOD_BUCKET;
                    end
                end
            end else if (r_a.read_item <= ITEM_TOTAL_LAST) begin
                if (r_a.read_scope == SCOPE_GLOBAL) begin
                    a_work.src = SRC_GLB_TOTAL;
                end else if (mod_in_range) begin
                    a_work.src = SRC_MOD_TOTAL;
                end
            end
        end else begin
            a_skip_next = skip_eff;
            if (skip_eff) begin
                a_work.status = ST_SKIPPED;
            end else if (mod_bad) begin
                a_work.status = ST_BAD_MODULE;
                a_skip_next   = 1'b1;
            end else if (r_a.rec_type == REC_UNKNOWN) begin
                // The record length is unknown, so the rest of the stream
                // cannot be parsed.
                a_work.status = ST_UNKNOWN_TYPE;
                a_skip_next   = 1'b1;
            end else begin
                a_work.counted = 1'b1;
                if (r_a.rec_type != REC_FREE) begin
                    a_work.inc_bucket = 1'b1;
                    a_work.bucket     = bin_bucket;
                end
            end
        end

        if (r_a.op == OP_READ) begin
            a_baddr = {r_a.module_req[MW-1:0], r_a.read_item[2:0]};
            a_taddr = {r_a.module_req[MW-1:0], r_a.read_item[1:0]};
        end else begin
            a_baddr = {r_a.module_req[MW-1:0], bin_bucket};
            a_taddr = {r_a.module_req[MW-1:0], r_a.rec_type};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
        end else if (fire_a) begin
            r_skip <= a_skip_next;
        end
    end

    // Update stage registers.
    t_work          r_b;
    logic [BAW-1:0] r_b_baddr;
    logic [TAW-1:0] r_b_taddr;
    logic           r_b_bfwd, r_b_tfwd;
    logic [CNT_W-1:0] r_b_bfwd_data, r_b_tfwd_data;

    // Memory write ports, shared with the clearing pass.
    logic             b_bwe, b_twe;
    logic [CNT_W-1:0] b_bnew, b_tnew;
    logic [CNT_W-1:0] ram_bdata, ram_tdata;
    logic [CNT_W-1:0] b_bcur, b_tcur;
    logic             bram_we, tram_we;
    logic [BAW-1:0]   bram_waddr;
    logic [TAW-1:0]   tram_waddr;
    logic [CNT_W-1:0] bram_wdata, tram_wdata;

    assign b_bwe  = fire_b && r_b.inc_bucket;
    assign b_twe  = fire_b && r_b.counted;
    assign b_bcur = r_b_bfwd ? r_b_bfwd_data : ram_bdata;
    assign b_tcur = r_b_tfwd ? r_b_tfwd_data : ram_tdata;
    assign b_bnew = sat_inc(b_bcur);
    assign b_tnew = sat_inc(b_tcur);

    assign bram_we    = r_clr_busy || b_bwe;
    assign bram_waddr = r_clr_busy ? r_clr_cnt : r_b_baddr;
    assign bram_wdata = r_clr_busy ? '0 : b_bnew;
    assign tram_we    = r_clr_busy || b_twe;
    assign tram_waddr = r_clr_busy ? r_clr_cnt[TAW-1:0] : r_b_taddr;
    assign tram_wdata = r_clr_busy ? '0 : b_tnew;

    asz_ram #(
        .AW(BAW),
        .DW(CNT_W)
    ) u_bucket_ram (
        .i_clk  (i_clk),
        .i_we   (bram_we),
        .i_waddr(bram_waddr),
        .i_wdata(bram_wdata),
        .i_re   (fire_a),
        .i_raddr(a_baddr),
        .o_rdata(ram_bdata)
    );

    asz_ram #(
        .AW(TAW),
        .DW(CNT_W)
    ) u_total_ram (
        .i_clk  (i_clk),
        .i_we   (tram_we),
        .i_waddr(tram_waddr),
        .i_wdata(tram_wdata),
        .i_re   (fire_a),
        .i_raddr(a_taddr),
        .o_rdata(ram_tdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (fire_a) begin
            r_b_valid <= 1'b1;
        end else if (fire_b) begin
            r_b_valid <= 1'b0;
        end
    end

    // The memory read at this edge misses a write to the same entry made at
    // the same edge, so that value is captured here instead.
    always_ff @(posedge i_clk) begin
        if (fire_a) begin
            r_b           <= a_work;
            r_b_baddr     <= a_baddr;
            r_b_taddr     <= a_taddr;
            r_b_bfwd      <= b_bwe && (r_b_baddr == a_baddr);
            r_b_tfwd      <= b_twe && (r_b_taddr == a_taddr);
            r_b_bfwd_data <= b_bnew;
            r_b_tfwd_data <= b_tnew;
        end
    end

    // Global counters.
    logic [CNT_W-1:0] r_glb_bucket [NBUCKETS];
    logic [CNT_W-1:0] r_glb_total  [NOPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NBUCKETS; i++) begin
                r_glb_bucket[i] <= '0;
            end
            for (int k = 0; k < NOPS; k++) begin
                r_glb_total[k] <= '0;
            end
        end else begin
            for (int i = 0; i < NBUCKETS; i++) begin
                if (b_bwe && (r_b.bucket == 3'(i))) begin
                    r_glb_bucket[i] <= sat_inc(r_glb_bucket[i]);
                end
            end
            for (int k = 0; k < NOPS; k++) begin
                if (b_twe && (r_b.rec_type == 2'(k))) begin
                    r_glb_total[k] <= sat_inc(r_glb_total[k]);
                end
            end
        end
    end

    logic [CNT_W-1:0] glb_total_sel;
    logic [CNT_W-1:0] b_value;

    always_comb begin
        if (r_b.read_item[1]) begin
            glb_total_sel = r_glb_total[2];
        end else if (r_b.read_item[0]) begin
            glb_total_sel = r_glb_total[1];
        end else begin
            glb_total_sel = r_glb_total[0];
        end

        unique case (r_b.src)
            SRC_MOD_BUCKET: b_value = b_bcur;
            SRC_MOD_TOTAL:  b_value = b_tcur;
            SRC_GLB_BUCKET: b_value = r_glb_bucket[r_b.read_item[2:0]];
            SRC_GLB_TOTAL:  b_value = glb_total_sel;
            default:        b_value = '0;
        endcase
    end

    // Result register.
    t_status          r_o_status;
    logic [2:0]       r_o_bucket;
    logic [CNT_W-1:0] r_o_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_space) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b) begin
            r_o_status <= r_b.status;
            r_o_bucket <= r_b.bucket;
            r_o_value  <= b_value;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {5'b0, r_o_value, r_o_bucket};
    assign o_m_tuser  = r_o_status;

endmodule

// ===== src/asz_checker.sv =====
module asz_checker
    import asz_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [39:0]          o_m_tdata,
    input logic [2:0]           o_m_tuser
);

    // Reset empties the pipeline and starts the clearing pass.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("word visible or accepted right after reset");

    // Only a counted record reports a bucket.
    a_bucket_only_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_COUNTED) |-> (o_m_tdata[2:0] == 3'd0))
        else $error("bucket set on a word that counted nothing");

    // Only a read returns a counter value.
    a_value_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_READ_DATA) |-> (o_m_tdata[34:3] == 32'd0))
        else $error("read value on a word that is not a read");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

endmodule

bind alloc_size_histogram asz_checker u_asz_checker (.*);
